// ----- hw/rtl/nmea_rmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nmea_rmc_pkg;

	// Saturation limits of the decoded numeric fields.
	localparam logic [29:0] LAT_CAP = 30'd99999999;
	localparam logic [29:0] LON_CAP = 30'd999999999;
	localparam logic [29:0] SPD_CAP = 30'd99999;

	// Fraction digits kept for position and for speed and course, one to six.
	localparam int POS_FRAC_DEFAULT = 4;
	localparam int SPD_FRAC_DEFAULT = 2;

	typedef struct packed {
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic        valid_res;
		logic [26:0] latitude;
		logic [29:0] longitude;
		logic [7:0]  east_west;
		logic [16:0] speed;
		logic [16:0] course;
		logic [6:0]  day;
		logic [6:0]  month;
		logic [6:0]  year;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nmea_rmc_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_parse #(
	parameter int POS_FRAC_DIGITS = nmea_rmc_pkg::POS_FRAC_DEFAULT,
	parameter int SPD_FRAC_DIGITS = nmea_rmc_pkg::SPD_FRAC_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            rx,
	input  wire logic                  step,
	output logic                       want_emit,
	output nmea_rmc_pkg::result_t      res
);
	import nmea_rmc_pkg::*;

	localparam logic [2:0] POS_PLACES = 3'(POS_FRAC_DIGITS);
	localparam logic [2:0] SPD_PLACES = 3'(SPD_FRAC_DIGITS);

	localparam logic [2:0] HDR_HUNT = 3'd0;
	localparam logic [2:0] HDR_IN   = 3'd6;

	localparam logic [3:0] FLD_HEAD   = 4'd0;
	localparam logic [3:0] FLD_TIME   = 4'd1;
	localparam logic [3:0] FLD_STATUS = 4'd2;
	localparam logic [3:0] FLD_LAT    = 4'd3;
	localparam logic [3:0] FLD_LON    = 4'd5;
	localparam logic [3:0] FLD_EW     = 4'd6;
	localparam logic [3:0] FLD_SPEED  = 4'd7;
	localparam logic [3:0] FLD_COURSE = 4'd8;
	localparam logic [3:0] FLD_DATE   = 4'd9;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;

	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd1:    c = 8'h47;
			3'd2:    c = 8'h4E;
			3'd3:    c = 8'h52;
			3'd4:    c = 8'h4D;
			3'd5:    c = 8'h43;
			default: c = CH_DOLLAR;
		endcase
		return c;
	endfunction

	function automatic logic [19:0] pow10(input logic [2:0] k);
		logic [19:0] p;
		unique case (k)
			3'd0:    p = 20'd1;
			3'd1:    p = 20'd10;
			3'd2:    p = 20'd100;
			3'd3:    p = 20'd1000;
			3'd4:    p = 20'd10000;
			3'd5:    p = 20'd100000;
			3'd6:    p = 20'd1000000;
			default: p = 20'd1;
		endcase
		return p;
	endfunction

	function automatic logic [6:0] bcd2bin(input logic [7:0] bcd);
		return {bcd[7:4], 3'b000} + {2'b00, bcd[7:4], 1'b0} + {3'b000, bcd[3:0]};
	endfunction

	logic [2:0]  hdr_q, hdr_d;
	logic [3:0]  fld_q, fld_d;
	logic        point_q, point_d;
	logic [2:0]  fc_q, fc_d;
	logic [29:0] acc_q, acc_d;
	logic [23:0] bcd_q, bcd_d;
	logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
	logic        ok_q, ok_d;
	logic [7:0]  ew_q, ew_d;
	logic [16:0] speed_q, speed_d, course_q, course_d;
	logic [26:0] lat_q, lat_d;
	logic [29:0] lon_q, lon_d;

	logic        is_digit;
	logic        is_pos;
	logic [2:0]  places;
	logic [29:0] cap;
	logic [49:0] prod;
	logic [29:0] scaled;
	logic [33:0] next_acc;
	logic        full;

	assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
	assign is_pos   = (fld_q == FLD_LAT) || (fld_q == FLD_LON);
	assign places   = is_pos ? POS_PLACES : SPD_PLACES;
	assign cap      = (fld_q == FLD_LAT) ? LAT_CAP : ((fld_q == FLD_LON) ? LON_CAP : SPD_CAP);

	// Missing fraction digits are filled in with one multiply, then clamped.
	assign prod     = acc_q * pow10(places - fc_q);
	assign scaled   = (prod > {20'd0, cap}) ? cap : prod[29:0];
	assign next_acc = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {30'd0, rx[3:0]};

	always_comb begin
		hdr_d    = hdr_q;
		fld_d    = fld_q;
		point_d  = point_q;
		fc_d     = fc_q;
		acc_d    = acc_q;
		bcd_d    = bcd_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		ok_d     = ok_q;
		ew_d     = ew_q;
		speed_d  = speed_q;
		course_d = course_q;
		lat_d    = lat_q;
		lon_d    = lon_q;
		want_emit = 1'b0;
		full      = 1'b0;

		priority if (rx == CH_DOLLAR) begin
			hdr_d    = 3'd1;
			fld_d    = FLD_HEAD;
			point_d  = 1'b0;
			fc_d     = 3'd0;
			acc_d    = '0;
			bcd_d    = '0;
			hour_d   = '0;
			minute_d = '0;
			second_d = '0;
			ok_d     = 1'b0;
			ew_d     = '0;
			speed_d  = '0;
			course_d = '0;
			lat_d    = '0;
			lon_d    = '0;
		end else if (hdr_q != HDR_IN) begin
			if ((hdr_q != HDR_HUNT) && (rx == hdr_char(hdr_q))) begin
				hdr_d = hdr_q + 3'd1;
			end else begin
				hdr_d = HDR_HUNT;
			end
			fld_d = FLD_HEAD;
		end else if (fld_q == FLD_HEAD) begin
			if (rx == CH_COMMA) begin
				fld_d   = FLD_TIME;
				point_d = 1'b0;
				fc_d    = 3'd0;
				acc_d   = '0;
				bcd_d   = '0;
			end
		end else if ((fld_q == FLD_STATUS) && (fc_q == 3'd0)) begin
			if (rx == CH_A) begin
				ok_d = 1'b1;
				fc_d = 3'd1;
			end else begin
				// Anything but A, an empty field too, ends the sentence at once.
				want_emit = 1'b1;
				hdr_d     = HDR_HUNT;
			end
		end else if (rx == CH_COMMA) begin
			if (fld_q >= FLD_DATE) begin
				want_emit = 1'b1;
				full      = 1'b1;
				hdr_d     = HDR_HUNT;
			end else begin
				unique case (fld_q)
					FLD_TIME: begin
						hour_d   = bcd2bin(bcd_q[23:16]);
						minute_d = bcd2bin(bcd_q[15:8]);
						second_d = bcd2bin(bcd_q[7:0]);
					end
					FLD_LAT:    lat_d    = scaled[26:0];
					FLD_LON:    lon_d    = scaled;
					FLD_SPEED:  speed_d  = scaled[16:0];
					FLD_COURSE: course_d = scaled[16:0];
					default: ;
				endcase
				fld_d   = fld_q + 4'd1;
				point_d = 1'b0;
				fc_d    = 3'd0;
				acc_d   = '0;
				bcd_d   = '0;
			end
		end else begin
			unique case (fld_q)
				FLD_TIME, FLD_DATE: begin
					// Only the last six digits of the integer part are kept.
					if (!point_q) begin
						if (is_digit) begin
							bcd_d = {bcd_q[19:0], rx[3:0]};
						end else begin
							point_d = 1'b1;
						end
					end
				end
				FLD_LAT, FLD_LON, FLD_SPEED, FLD_COURSE: begin
					if (is_digit) begin
						if (!(point_q && (fc_q >= places))) begin
							acc_d = (next_acc > {4'd0, cap}) ? cap : next_acc[29:0];
							if (point_q) begin
								fc_d = fc_q + 3'd1;
							end
						end
					end else if (rx == CH_POINT) begin
						point_d = 1'b1;
					end
				end
				FLD_EW: begin
					if (fc_q == 3'd0) begin
						ew_d = rx;
						fc_d = 3'd1;
					end
				end
				default: ;
			endcase
		end

		res.hour      = hour_q;
		res.minute    = minute_q;
		res.second    = second_q;
		res.valid_res = full ? ok_q : 1'b0;
		res.latitude  = full ? lat_q : '0;
		res.longitude = full ? lon_q : '0;
		res.east_west = full ? ew_q : '0;
		res.speed     = full ? speed_q : '0;
		res.course    = full ? course_q : '0;
		res.day       = full ? bcd2bin(bcd_q[23:16]) : '0;
		res.month     = full ? bcd2bin(bcd_q[15:8]) : '0;
		res.year      = full ? bcd2bin(bcd_q[7:0]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= HDR_HUNT;
			fld_q    <= FLD_HEAD;
			point_q  <= 1'b0;
			fc_q     <= 3'd0;
			acc_q    <= '0;
			bcd_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			ok_q     <= 1'b0;
			ew_q     <= '0;
			speed_q  <= '0;
			course_q <= '0;
			lat_q    <= '0;
			lon_q    <= '0;
		end else if (step) begin
			hdr_q    <= hdr_d;
			fld_q    <= fld_d;
			point_q  <= point_d;
			fc_q     <= fc_d;
			acc_q    <= acc_d;
			bcd_q    <= bcd_d;
			hour_q   <= hour_d;
			minute_q <= minute_d;
			second_q <= second_d;
			ok_q     <= ok_d;
			ew_q     <= ew_d;
			speed_q  <= speed_d;
			course_q <= course_d;
			lat_q    <= lat_d;
			lon_q    <= lon_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/nmea_rmc_out.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_out (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire nmea_rmc_pkg::result_t res_in,
	input  wire logic                  stall,
	output logic                       free,
	output logic                       valid,
	output nmea_rmc_pkg::result_t      res
);
	import nmea_rmc_pkg::*;

	logic    valid_q;
	result_t res_q;

	// The register can take a new request when empty or when its current one leaves.
	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/nmea_rmc_sentence_parser_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A result is presented in the cycle after the byte that completes it is consumed.
// Throughput: one byte per cycle unless in_stall is high; each byte passes the parser
// once, and the longest path is the 30 by 20 bit multiply that pads missing fraction
// digits at a field's comma. Reset (arst_n low, asynchronous) empties both registers and
// returns the parser to hunting for the dollar sign with all captured fields cleared.
module nmea_rmc_sentence_parser_top #(
	parameter int POS_FRAC_DIGITS = nmea_rmc_pkg::POS_FRAC_DEFAULT,
	parameter int SPD_FRAC_DIGITS = nmea_rmc_pkg::SPD_FRAC_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       hour,
	output logic [6:0]       minute,
	output logic [6:0]       second,
	output logic             valid_res,
	output logic [26:0]      latitude,
	output logic [29:0]      longitude,
	output logic [7:0]       east_west,
	output logic [16:0]      speed,
	output logic [16:0]      course,
	output logic [6:0]       day,
	output logic [6:0]       month,
	output logic [6:0]       year
);
	import nmea_rmc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       want_emit;
	logic       out_free;
	logic       consume;
	result_t    res_next;
	result_t    res_out;

	// A byte that ends a sentence waits in the input register until the output has room.
	assign consume  = valid_s1 && (!want_emit || out_free);
	assign in_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	nmea_rmc_parse #(
		.POS_FRAC_DIGITS (POS_FRAC_DIGITS),
		.SPD_FRAC_DIGITS (SPD_FRAC_DIGITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (byte_s1),
		.step      (consume),
		.want_emit (want_emit),
		.res       (res_next)
	);

	nmea_rmc_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume && want_emit),
		.res_in (res_next),
		.stall  (out_stall),
		.free   (out_free),
		.valid  (out_valid),
		.res    (res_out)
	);

	assign hour      = res_out.hour;
	assign minute    = res_out.minute;
	assign second    = res_out.second;
	assign valid_res = res_out.valid_res;
	assign latitude  = res_out.latitude;
	assign longitude = res_out.longitude;
	assign east_west = res_out.east_west;
	assign speed     = res_out.speed;
	assign course    = res_out.course;
	assign day       = res_out.day;
	assign month     = res_out.month;
	assign year      = res_out.year;

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && want_emit && !consume) |-> (out_valid && out_stall))
		else $error("result byte held without a blocked output");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && want_emit) |=> out_valid)
		else $error("loaded result not presented");

	a_caps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((latitude <= LAT_CAP[26:0]) && (longitude <= LON_CAP)
			&& (speed <= SPD_CAP[16:0]) && (course <= SPD_CAP[16:0])))
		else $error("numeric field above its saturation limit");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> ((latitude == '0) && (longitude == '0)
			&& (speed == '0) && (course == '0) && (day == '0)))
		else $error("invalid-status result carries position or date");

endmodule

`default_nettype wire
